### hdl/mpgb_pkg.sv
// Shared constants, types and register codes of the max pool, gain and bias block.
package mpgb_pkg;

  // Default sizes.
  localparam int DEF_MAX_MAP_WIDTH = 256;
  localparam int DEF_MAX_WINDOW    = 16;
  localparam int DEF_PIXEL_BITS    = 16;

  // Fixed row limit and counter widths.
  localparam int HEIGHT_LIMIT = 256;
  localparam int ROW_BITS     = 8;
  localparam int OUT_POS_BITS = 8;
  localparam int POOLED_BITS  = 32;
  localparam int COEF_BITS    = 16;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

  localparam cfg_index_t REG_WINDOW_WIDTH  = 3'd0;
  localparam cfg_index_t REG_WINDOW_HEIGHT = 3'd1;
  localparam cfg_index_t REG_MAP_WIDTH     = 3'd2;
  localparam cfg_index_t REG_MAP_HEIGHT    = 3'd3;
  localparam cfg_index_t REG_GAIN          = 3'd4;
  localparam cfg_index_t REG_BIAS          = 3'd5;

  // Register reset values.
  localparam logic [4:0]  RST_WINDOW_WIDTH  = 5'd2;
  localparam logic [4:0]  RST_WINDOW_HEIGHT = 5'd2;
  localparam logic [8:0]  RST_MAP_WIDTH     = 9'd28;
  localparam logic [8:0]  RST_MAP_HEIGHT    = 9'd28;
  localparam logic [15:0] RST_GAIN          = 16'd256;
  localparam logic [15:0] RST_BIAS          = 16'd0;

  // Output payload width: pooled, out_col, out_row.
  localparam int OUT_DATA_BITS = POOLED_BITS + 2 * OUT_POS_BITS;

endpackage

### hdl/max_pool_gain_bias.sv
// Top level of the max pool, gain and bias block.
//
// Streams one feature map in raster order (signed Q8.8 pixels on s_tdata) and
// pools non-overlapping window_width x window_height windows to their maximum.
// For each full window it emits max * gain + (bias << 8) as signed Q16.16,
// with the pooled column and row, and marks the final result of the map with
// m_tlast. Windows cut off by the right or bottom map edge produce nothing.
// The block takes one pixel per clock unless the output stalls: the running
// maximum of each pooled column lives in a line memory with a registered read,
// and a write-to-read bypass lets consecutive pixels of the same column update
// it back to back. A result forms from the clock edge that accepts the window's
// last pixel: the memory read is issued at that edge, then come the compare and
// multiply, then the bias add into the output register, a stall holding each step.
// Back-pressure on m_tready stalls the whole pipeline; a stalled result holds.
// Write configuration only while the block is idle; gain and bias are sampled
// as results pass through, so change them between maps.
module max_pool_gain_bias #(
  parameter int MAX_MAP_WIDTH = mpgb_pkg::DEF_MAX_MAP_WIDTH,
  parameter int MAX_WINDOW    = mpgb_pkg::DEF_MAX_WINDOW,
  parameter int PIXEL_BITS    = mpgb_pkg::DEF_PIXEL_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Pixel input stream.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]      s_tdata,   // [PIXEL_BITS-1:0] pixel
  // Pooled result stream.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [mpgb_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // [31:0] pooled, [39:32] out_col,
                                                          // [47:40] out_row
  output logic                                 m_tlast,   // last_of_map
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  mpgb_pkg::cfg_index_t                 cfg_index,
  input  mpgb_pkg::cfg_data_t                  cfg_data
);
  import mpgb_pkg::*;

  localparam int COL_BITS = $clog2(MAX_MAP_WIDTH);       // line memory address
  localparam int MW_BITS  = $clog2(MAX_MAP_WIDTH + 1);   // effective map width
  localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);      // effective window size
  localparam int PH_BITS  = $clog2(MAX_WINDOW);          // phase inside window
  localparam int MH_BITS  = $clog2(HEIGHT_LIMIT + 1);
  localparam int CMP_BITS = 32;
  localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;

  // Configuration registers.
  logic [4:0]  window_width;
  logic [4:0]  window_height;
  logic [8:0]  map_width;
  logic [8:0]  map_height;
  logic signed [COEF_BITS-1:0] gain;
  logic signed [COEF_BITS-1:0] bias;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= RST_WINDOW_WIDTH;
      window_height <= RST_WINDOW_HEIGHT;
      map_width     <= RST_MAP_WIDTH;
      map_height    <= RST_MAP_HEIGHT;
      gain          <= RST_GAIN;
      bias          <= RST_BIAS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[4:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[4:0];
        REG_MAP_WIDTH:     map_width     <= cfg_data[8:0];
        REG_MAP_HEIGHT:    map_height    <= cfg_data[8:0];
        REG_GAIN:          gain          <= cfg_data;
        REG_BIAS:          bias          <= cfg_data;
        default: ;  // unused indexes: drop the write
      endcase
    end
  end

  // Effective sizes: zero counts as one, oversize clamps to the limit.
  logic [WIN_BITS-1:0] ww_eff, wh_eff;
  logic [MW_BITS-1:0]  mw_eff;
  logic [MH_BITS-1:0]  mh_eff;

  always_comb begin
    if (window_width == '0)
      ww_eff = WIN_BITS'(1);
    else if (CMP_BITS'(window_width) > CMP_BITS'(MAX_WINDOW))
      ww_eff = WIN_BITS'(MAX_WINDOW);
    else
      ww_eff = WIN_BITS'(window_width);

    if (window_height == '0)
      wh_eff = WIN_BITS'(1);
    else if (CMP_BITS'(window_height) > CMP_BITS'(MAX_WINDOW))
      wh_eff = WIN_BITS'(MAX_WINDOW);
    else
      wh_eff = WIN_BITS'(window_height);

    if (map_width == '0)
      mw_eff = MW_BITS'(1);
    else if (CMP_BITS'(map_width) > CMP_BITS'(MAX_MAP_WIDTH))
      mw_eff = MW_BITS'(MAX_MAP_WIDTH);
    else
      mw_eff = MW_BITS'(map_width);

    if (map_height == '0)
      mh_eff = MH_BITS'(1);
    else if (CMP_BITS'(map_height) > CMP_BITS'(HEIGHT_LIMIT))
      mh_eff = MH_BITS'(HEIGHT_LIMIT);
    else
      mh_eff = MH_BITS'(map_height);
  end

  // Scan position of the next pixel.
  logic [COL_BITS-1:0] in_col, pool_col;
  logic [ROW_BITS-1:0] in_row, pool_row;
  logic [PH_BITS-1:0]  win_col_phase, win_row_phase;

  // Pipeline control: every stage moves together when the output can drain.
  logic advance, in_accept;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign in_accept = s_tvalid && advance;

  // Decode of the incoming pixel's place in its window.
  logic col_in_range, row_in_range, col_last, row_last;
  logic col_phase_end, row_phase_end, col_end, row_end;
  logic win_active, win_first, win_emit;

  always_comb begin
    col_in_range = (CMP_BITS'(pool_col) + 1) * CMP_BITS'(ww_eff) <= CMP_BITS'(mw_eff);
    row_in_range = (CMP_BITS'(pool_row) + 1) * CMP_BITS'(wh_eff) <= CMP_BITS'(mh_eff);
    // Final full window: the next one would not fit.
    col_last = (CMP_BITS'(pool_col) + 2) * CMP_BITS'(ww_eff) > CMP_BITS'(mw_eff);
    row_last = (CMP_BITS'(pool_row) + 2) * CMP_BITS'(wh_eff) > CMP_BITS'(mh_eff);
    col_phase_end = CMP_BITS'(win_col_phase) + 1 >= CMP_BITS'(ww_eff);
    row_phase_end = CMP_BITS'(win_row_phase) + 1 >= CMP_BITS'(wh_eff);
    col_end = CMP_BITS'(in_col) + 1 >= CMP_BITS'(mw_eff);
    row_end = CMP_BITS'(in_row) + 1 >= CMP_BITS'(mh_eff);
    win_active = col_in_range && row_in_range;
    win_first  = (win_col_phase == '0) && (win_row_phase == '0);
    win_emit   = col_phase_end && row_phase_end;
  end

  // Advance the scan position on every accepted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col        <= '0;
      in_row        <= '0;
      win_col_phase <= '0;
      win_row_phase <= '0;
      pool_col      <= '0;
      pool_row      <= '0;
    end else if (in_accept) begin
      if (col_end) begin
        in_col        <= '0;
        win_col_phase <= '0;
        pool_col      <= '0;
        if (row_end) begin
          in_row        <= '0;
          win_row_phase <= '0;
          pool_row      <= '0;
        end else begin
          in_row <= in_row + 1'b1;
          if (row_phase_end) begin
            win_row_phase <= '0;
            pool_row      <= pool_row + 1'b1;
          end else begin
            win_row_phase <= win_row_phase + 1'b1;
          end
        end
      end else begin
        in_col <= in_col + 1'b1;
        if (col_phase_end) begin
          win_col_phase <= '0;
          pool_col      <= pool_col + 1'b1;
        end else begin
          win_col_phase <= win_col_phase + 1'b1;
        end
      end
    end
  end

  // Stage 1: line memory read issued, pixel and window decode held.
  logic                         s1_valid;
  logic                         s1_first, s1_emit, s1_last;
  logic signed [PIXEL_BITS-1:0] s1_pixel;
  logic [COL_BITS-1:0]          s1_col;
  logic [ROW_BITS-1:0]          s1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_accept && win_active;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_first <= win_first;
      s1_emit  <= win_emit;
      s1_last  <= col_last && row_last;
      s1_pixel <= s_tdata[PIXEL_BITS-1:0];
      s1_col   <= pool_col;
      s1_row   <= pool_row;
    end
  end

  // Line memory of running column maxima, with a bypass of the write made in
  // the same cycle as the pending read.
  logic signed [PIXEL_BITS-1:0] column_max [MAX_MAP_WIDTH];
  logic signed [PIXEL_BITS-1:0] rd_data;
  logic                         fwd_valid;
  logic [COL_BITS-1:0]          fwd_addr;
  logic signed [PIXEL_BITS-1:0] fwd_data;
  logic signed [PIXEL_BITS-1:0] stored_max, new_max;
  logic                         wr_en;

  always_comb begin
    stored_max = (fwd_valid && fwd_addr == s1_col) ? fwd_data : rd_data;
    if (s1_first || s1_pixel > stored_max)
      new_max = s1_pixel;
    else
      new_max = stored_max;
    wr_en = advance && s1_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_valid)
        column_max[s1_col] <= new_max;
      rd_data <= column_max[pool_col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (advance) begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_addr <= s1_col;
      fwd_data <= new_max;
    end
  end

  // Stage 2: gain product of the finished window maximum.
  logic                        s2_valid, s2_last;
  logic signed [PROD_BITS-1:0] s2_prod;
  logic [ROW_BITS-1:0]         s2_row;
  logic [COL_BITS-1:0]         s2_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_prod <= PROD_BITS'(new_max) * PROD_BITS'(gain);
      s2_col  <= s1_col;
      s2_row  <= s1_row;
      s2_last <= s1_last;
    end
  end

  // Stage 3: bias add into the output register.
  logic signed [POOLED_BITS-1:0] prod_w, bias_w;
  logic signed [POOLED_BITS-1:0] pooled;
  logic [OUT_POS_BITS-1:0]       out_col, out_row;
  logic                          last_of_map;

  always_comb begin
    prod_w = POOLED_BITS'(s2_prod);
    bias_w = POOLED_BITS'(bias);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pooled      <= prod_w + (bias_w <<< 8);
      out_col     <= OUT_POS_BITS'(s2_col);
      out_row     <= OUT_POS_BITS'(s2_row);
      last_of_map <= s2_last;
    end
  end

  assign m_tdata = {out_row, out_col, pooled};
  assign m_tlast = last_of_map;

endmodule

### tb/sv/mpgb_result_check.sv
// Result checker for the max pool, gain and bias block: predicts pooled results and compares.
module mpgb_result_check (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [15:0]                        s_tdata,    // [15:0] pixel
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [mpgb_pkg::OUT_DATA_BITS-1:0] m_tdata,    // [31:0] pooled, [39:32] out_col,
                                                         // [47:40] out_row
  input  logic                               m_tlast,    // last_of_map
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  mpgb_pkg::cfg_index_t               cfg_index,
  input  mpgb_pkg::cfg_data_t                cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  import mpgb_pkg::*;

  localparam int LINE_DEPTH = DEF_MAX_MAP_WIDTH;
  localparam int WINDOW_CAP = DEF_MAX_WINDOW;

  typedef struct packed {
    logic signed [31:0] pooled;
    logic [7:0]         col;
    logic [7:0]         row;
    logic               last;
  } pool_result_t;

  pool_result_t pooled_expect_q[$];

  logic [4:0]         win_w_raw, win_h_raw;
  logic [8:0]         map_w_raw, map_h_raw;
  logic signed [15:0] gain_q88, bias_q88;

  // Running maximum per pooled column.
  logic signed [15:0] column_peak [LINE_DEPTH];
  int unsigned        col_pos, row_pos, x_phase, y_phase, pool_x, pool_y;
  bit                 col_fits, row_fits;

  function automatic int unsigned clamp_size(int unsigned raw, int unsigned hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  task automatic update_fit();
    col_fits = (pool_x + 1) * clamp_size(win_w_raw, WINDOW_CAP)
               <= clamp_size(map_w_raw, LINE_DEPTH);
    row_fits = (pool_y + 1) * clamp_size(win_h_raw, WINDOW_CAP)
               <= clamp_size(map_h_raw, HEIGHT_LIMIT);
  endtask

  task automatic apply_write(input cfg_index_t idx, input cfg_data_t val);
    case (idx)
      REG_WINDOW_WIDTH:  win_w_raw = val[4:0];
      REG_WINDOW_HEIGHT: win_h_raw = val[4:0];
      REG_MAP_WIDTH:     map_w_raw = val[8:0];
      REG_MAP_HEIGHT:    map_h_raw = val[8:0];
      REG_GAIN:          gain_q88  = val;
      REG_BIAS:          bias_q88  = val;
      default: ;
    endcase
    update_fit();
  endtask

  task automatic pool_pixel(input logic signed [15:0] px);
    int unsigned        ww, wh, mw, mh;
    logic signed [15:0] peak;
    pool_result_t       res;
    ww = clamp_size(win_w_raw, WINDOW_CAP);
    wh = clamp_size(win_h_raw, WINDOW_CAP);
    mw = clamp_size(map_w_raw, LINE_DEPTH);
    mh = clamp_size(map_h_raw, HEIGHT_LIMIT);
    if (col_fits && row_fits && pool_x < LINE_DEPTH) begin
      if (x_phase == 0 && y_phase == 0) peak = px;
      else peak = (column_peak[pool_x] > px) ? column_peak[pool_x] : px;
      column_peak[pool_x] = peak;
      if (x_phase + 1 >= ww && y_phase + 1 >= wh) begin
        res.pooled = 32'(longint'(peak) * longint'(gain_q88) + longint'(bias_q88) * 256);
        res.col    = 8'(pool_x);
        res.row    = 8'(pool_y);
        res.last   = (pool_x + 1 == mw / ww) && (pool_y + 1 == mh / wh);
        pooled_expect_q.push_back(res);
      end
    end
    // Advance the raster position, wrapping at row and map end.
    if (col_pos + 1 >= mw) begin
      col_pos = 0;
      x_phase = 0;
      pool_x  = 0;
      if (row_pos + 1 >= mh) begin
        row_pos = 0;
        y_phase = 0;
        pool_y  = 0;
      end else begin
        row_pos++;
        if (y_phase + 1 >= wh) begin
          y_phase = 0;
          pool_y++;
        end else begin
          y_phase++;
        end
      end
    end else begin
      col_pos++;
      if (x_phase + 1 >= ww) begin
        x_phase = 0;
        pool_x++;
      end else begin
        x_phase++;
      end
    end
    update_fit();
  endtask

  task automatic check_result();
    pool_result_t want;
    if (pooled_expect_q.size() == 0) begin
      $error("unexpected result: pooled %0d, out_col %0d, out_row %0d, last_of_map %0b",
             $signed(m_tdata[31:0]), m_tdata[39:32], m_tdata[47:40], m_tlast);
      fail_count++;
    end else begin
      want = pooled_expect_q.pop_front();
      if (m_tdata[31:0] !== want.pooled) begin
        $error("pooled: expected %0d, actual %0d", want.pooled, $signed(m_tdata[31:0]));
        fail_count++;
      end
      if (m_tdata[39:32] !== want.col) begin
        $error("out_col: expected %0d, actual %0d", want.col, m_tdata[39:32]);
        fail_count++;
      end
      if (m_tdata[47:40] !== want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, m_tdata[47:40]);
        fail_count++;
      end
      if (m_tlast !== want.last) begin
        $error("last_of_map: expected %0b, actual %0b", want.last, m_tlast);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      win_w_raw  = RST_WINDOW_WIDTH;
      win_h_raw  = RST_WINDOW_HEIGHT;
      map_w_raw  = RST_MAP_WIDTH;
      map_h_raw  = RST_MAP_HEIGHT;
      gain_q88   = RST_GAIN;
      bias_q88   = RST_BIAS;
      col_pos    = 0;
      row_pos    = 0;
      x_phase    = 0;
      y_phase    = 0;
      pool_x     = 0;
      pool_y     = 0;
      fail_count = 0;
      pooled_expect_q.delete();
      update_fit();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) pool_pixel(s_tdata);
    end
    pending = pooled_expect_q.size();
  end

endmodule

### tb/sv/tb_max_pool_gain_bias.sv
// Testbench top for the max pool, gain and bias block: stimulus, idling and verdict.
module tb_max_pool_gain_bias;
  import mpgb_pkg::*;

  // Unused register indexes; writes to them must be ignored.
  localparam cfg_index_t REG_SPARE_6 = 3'd6;
  localparam cfg_index_t REG_SPARE_7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES   = 8;     // covers the three-stage result pipeline
  localparam int PIXEL_TARGET   = 800;   // includes the two full-width/height maps
  localparam int CALM_FROM      = 700;   // phases begun past this many pixels run without idling

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [15:0]              s_tdata;     // [15:0] pixel
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_DATA_BITS-1:0] m_tdata;     // [31:0] pooled, [39:32] out_col, [47:40] out_row
  logic                     m_tlast;     // last_of_map
  logic                     cfg_valid;
  logic                     cfg_ready;
  cfg_index_t               cfg_index;
  cfg_data_t                cfg_data;

  int fail_count;
  int expect_count;
  int fed_pixels;
  int feed_idle_pct;
  int sink_stall_pct;
  int quiet_cycles;

  max_pool_gain_bias dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mpgb_result_check result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (expect_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result sink: hold m_tready low in random bursts, one assignment per falling edge.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 99) < sink_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // Watchdog: end the run when no transaction happens on any channel for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Effective map span of a size register (zero means one, capped at the limit).
  function automatic int span(int raw, int hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Mostly random words, with the signed extremes, zero and minus one mixed in.
  function automatic logic [15:0] pick_word(int extreme_pct);
    if ($urandom_range(0, 99) >= extreme_pct) return 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Window size: mostly 1..4, sometimes zero, sometimes past the 16 cap.
  function automatic int pick_window();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return 0;
    if (roll < 4) return $urandom_range(5, 31);
    return $urandom_range(1, 4);
  endfunction

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write every register; sometimes also poke an unused index.
  task automatic load_settings(input cfg_data_t ww, input cfg_data_t wh, input cfg_data_t mw,
                               input cfg_data_t mh, input cfg_data_t gain,
                               input cfg_data_t bias);
    write_reg(REG_WINDOW_WIDTH, ww);
    write_reg(REG_WINDOW_HEIGHT, wh);
    write_reg(REG_MAP_WIDTH, mw);
    write_reg(REG_MAP_HEIGHT, mh);
    write_reg(REG_GAIN, gain);
    write_reg(REG_BIAS, bias);
    if ($urandom_range(0, 4) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Present one pixel and hold it until the transaction completes. An idle burst, if any,
  // drops s_tvalid on one falling edge and raises it on a later one.
  task automatic send_pixel(input logic [15:0] px);
    @(negedge clk);
    if ($urandom_range(0, 99) < feed_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    fed_pixels++;
  endtask

  // Close a phase: drop s_tvalid, wait out every expected result, then let the
  // pipeline drain so trailing pixels of partial windows are done before the next write.
  task automatic finish_phase();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expect_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One random phase: new settings, then whole maps. Kind 1 runs one map of full width,
  // kind 2 one map of full height; both reach bit 8 of the map size registers.
  task automatic random_phase(input int kind);
    int        ww, wh, mw, mh, maps, count;
    cfg_data_t ww_word, wh_word, mw_word, mh_word;
    ww   = pick_window();
    wh   = pick_window();
    mw   = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
    mh   = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
    maps = $urandom_range(1, 2);
    if (kind == 1) begin
      mw   = $urandom_range(256, 511);
      mh   = $urandom_range(0, 1);
      wh   = 1;
      maps = 1;
    end else if (kind == 2) begin
      mw   = $urandom_range(0, 1);
      mh   = $urandom_range(256, 511);
      ww   = 1;
      maps = 1;
    end
    // Fill unused upper bits with junk now and then; the block must ignore them.
    ww_word = ($urandom_range(0, 3) == 0) ? {11'($urandom), 5'(ww)} : 16'(ww);
    wh_word = ($urandom_range(0, 3) == 0) ? {11'($urandom), 5'(wh)} : 16'(wh);
    mw_word = ($urandom_range(0, 3) == 0) ? {7'($urandom), 9'(mw)} : 16'(mw);
    mh_word = ($urandom_range(0, 3) == 0) ? {7'($urandom), 9'(mh)} : 16'(mh);
    load_settings(ww_word, wh_word, mw_word, mh_word, pick_word(25), pick_word(25));
    count = span(mw, DEF_MAX_MAP_WIDTH) * span(mh, HEIGHT_LIMIT) * maps;
    repeat (count) send_pixel(pick_word(12));
    finish_phase();
  endtask

  initial begin
    int phase_no;
    int roll;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_WINDOW_WIDTH;
    cfg_data       = '0;
    fed_pixels     = 0;
    feed_idle_pct  = 0;
    sink_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 2x2 windows on a 4x2 map, largest gain and most negative bias. The second window
    // is all negative, so its maximum must come from its own first pixel.
    load_settings(16'd2, 16'd2, 16'd4, 16'd2, 16'h7FFF, 16'h8000);
    send_pixel(16'h7FFF); send_pixel(16'h8000); send_pixel(16'hFFFE); send_pixel(16'hFFFD);
    send_pixel(16'h8000); send_pixel(16'h7FFF); send_pixel(16'h8000); send_pixel(16'hFFFC);
    finish_phase();

    // Zero window and map sizes act as one: every pixel is a map of its own.
    // Most negative gain times most negative pixel gives the largest result.
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF);
    send_pixel(16'h8000); send_pixel(16'h7FFF);
    finish_phase();

    // Window wider than the map: pixels are counted, nothing comes out.
    load_settings(16'd3, 16'd1, 16'd2, 16'd1, 16'h0100, 16'h0000);
    send_pixel(16'h1234); send_pixel(16'hEDCB);
    finish_phase();

    // 3x3 map with 2x2 windows: the right column and bottom row are partial and dropped.
    load_settings(16'd2, 16'd2, 16'd3, 16'd3, 16'hFFFF, 16'h0001);
    send_pixel(16'h8000); send_pixel(16'h8001); send_pixel(16'h0005);
    send_pixel(16'h8000); send_pixel(16'h8002); send_pixel(16'h0007);
    send_pixel(16'h1234); send_pixel(16'h4321); send_pixel(16'h7FFF);
    finish_phase();

    // Random maps with random idling; the tail of the run streams without gaps.
    phase_no = 0;
    while (fed_pixels < PIXEL_TARGET) begin
      if (fed_pixels >= CALM_FROM) begin
        feed_idle_pct  = 0;
        sink_stall_pct = 0;
      end else begin
        roll           = $urandom_range(0, 2);
        feed_idle_pct  = (roll == 0) ? 0 : (roll == 1) ? 10 : 35;
        roll           = $urandom_range(0, 2);
        sink_stall_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : 35;
      end
      random_phase((phase_no == 1) ? 1 : (phase_no == 3) ? 2 : 0);
      phase_no++;
    end

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/mpgb_pkg.sv
hdl/max_pool_gain_bias.sv
tb/sv/mpgb_result_check.sv
tb/sv/tb_max_pool_gain_bias.sv
